>>> hw/rtl/pfc_pkg.sv
package pfc_pkg;

    // Square geometry and letter codes (letter index 0 = a)
    localparam logic [2:0] SIDE_LAST = 3'd4;
    localparam logic [4:0] CELLS     = 5'd25;
    localparam logic [4:0] LETTERS   = 5'd26;
    localparam logic [4:0] LET_I     = 5'd8;
    localparam logic [4:0] LET_J     = 5'd9;
    localparam logic [4:0] LET_X     = 5'd23;

    localparam logic [7:0] ASCII_UPPER_A = 8'd65;
    localparam logic [7:0] ASCII_UPPER_Z = 8'd90;
    localparam logic [7:0] ASCII_LOWER_A = 8'd97;
    localparam logic [7:0] ASCII_LOWER_Z = 8'd122;
    localparam logic [6:0] OUT_BASE      = 7'd97;

    typedef enum logic [1:0] {
        OP_CLEAR  = 2'd0,
        OP_KEY    = 2'd1,
        OP_FINISH = 2'd2,
        OP_TEXT   = 2'd3
    } t_opcode;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FILL,
        ST_POS,
        ST_SQ,
        ST_EMIT2
    } t_state;

    typedef struct packed {
        t_opcode    opcode;
        logic [7:0] char_byte;
        logic       message_last;
    } t_in;

    typedef struct packed {
        logic [6:0] letter;
        logic       pair_second;
        logic       message_end;
    } t_out;

    typedef struct packed {
        logic       valid;
        logic [4:0] idx;
    } t_letter;

    // ASCII byte to letter index, j folded into i
    function automatic t_letter letter_of(input logic [7:0] b);
        t_letter    r;
        logic [7:0] v;
        r.valid = 1'b0;
        v       = 8'd0;
        if (b >= ASCII_UPPER_A && b <= ASCII_UPPER_Z) begin
            v       = b - ASCII_UPPER_A;
            r.valid = 1'b1;
        end else if (b >= ASCII_LOWER_A && b <= ASCII_LOWER_Z) begin
            v       = b - ASCII_LOWER_A;
            r.valid = 1'b1;
        end
        r.idx = v[4:0];
        if (r.idx == LET_J) begin
            r.idx = LET_I;
        end
        return r;
    endfunction

    // Row of a cell index below 25
    function automatic logic [2:0] row_of(input logic [4:0] p);
        logic [2:0] r;
        if (p >= 5'd20)      r = 3'd4;
        else if (p >= 5'd15) r = 3'd3;
        else if (p >= 5'd10) r = 3'd2;
        else if (p >= 5'd5)  r = 3'd1;
        else                 r = 3'd0;
        return r;
    endfunction

    // Column of a cell index below 25
    function automatic logic [2:0] col_of(input logic [4:0] p);
        logic [2:0] r;
        logic [4:0] base;
        logic [4:0] diff;
        r    = row_of(p);
        base = {r, 2'b00} + {2'b00, r};
        diff = p - base;
        return diff[2:0];
    endfunction

    // One step around the row or column, backward for decrypt
    function automatic logic [2:0] shift5(input logic [2:0] x, input logic back);
        logic [2:0] r;
        if (back) r = (x == 3'd0) ? SIDE_LAST : x - 3'd1;
        else      r = (x == SIDE_LAST) ? 3'd0 : x + 3'd1;
        return r;
    endfunction

    function automatic logic [4:0] cell_of(input logic [2:0] row, input logic [2:0] col);
        return {row, 2'b00} + {2'b00, row} + {2'b00, col};
    endfunction

endpackage

>>> hw/rtl/pfc_ram.sv
module pfc_ram #(
    parameter int WIDTH = 5,
    parameter int DEPTH = 26,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr0,
    input  logic [AW-1:0]    i_raddr1,
    output logic [WIDTH-1:0] o_rdata0,
    output logic [WIDTH-1:0] o_rdata1
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata0;
    logic [WIDTH-1:0] r_rdata1;

    // One write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Two registered read ports, data holds between reads
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata0 <= r_mem[i_raddr0];
            r_rdata1 <= r_mem[i_raddr1];
        end
    end

    assign o_rdata0 = r_rdata0;
    assign o_rdata1 = r_rdata1;

endmodule

>>> hw/rtl/playfair_cipher_engine.sv
// Pair path: a text byte that completes a pair reads its two places, then its two square
// cells, then presents its first letter and its second one, each held under output backpressure.
// Input is refused (o_in_ready low) until the pair's second letter is registered or the finish
// walk over all 26 letters ends; key bytes and clears complete while idle.
// Reset: synchronous active low; clears used bits, fill count, held letter and direction.
// The square and place memories are not cleared; a key must be built before text.
module playfair_cipher_engine (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  pfc_pkg::t_in  i_in_data,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output pfc_pkg::t_out o_out_data,
    input  logic          i_cfg_valid,
    output logic          o_cfg_ready,
    input  logic          i_cfg_data
);

    pfc_pkg::t_state r_state, n_state;
    logic [25:0]     r_used, n_used;
    logic [4:0]      r_fill, n_fill;
    logic [4:0]      r_held, n_held;
    logic            r_held_v, n_held_v;
    logic            r_dir;
    logic [4:0]      r_walk, n_walk;
    logic            r_end, n_end;
    logic            r_out_valid, n_out_valid;
    pfc_pkg::t_out   r_out, n_out;

    pfc_pkg::t_letter lt;
    logic             in_fire;
    logic             out_free;
    logic             pair_go;
    logic [4:0]       pair_a;
    logic [4:0]       pair_b;
    logic             pair_end;

    logic             place_we;
    logic [4:0]       place_letter;
    logic [4:0]       place_rd0;
    logic [4:0]       place_rd1;
    logic [4:0]       sq_addr0;
    logic [4:0]       sq_addr1;
    logic [4:0]       sq_rd0;
    logic [4:0]       sq_rd1;
    logic             sq_re;

    logic [2:0]       r1, c1, r2, c2;

    assign lt          = pfc_pkg::letter_of(i_in_data.char_byte);
    assign in_fire     = i_in_valid && o_in_ready;
    assign out_free    = !r_out_valid || i_out_ready;
    assign o_in_ready  = (r_state == pfc_pkg::ST_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // Pair formation from a text transaction
    always_comb begin
        pair_go  = 1'b0;
        pair_a   = r_held;
        pair_b   = lt.idx;
        pair_end = i_in_data.message_last;
        if (in_fire && i_in_data.opcode == pfc_pkg::OP_TEXT) begin
            if (lt.valid) begin
                if (r_held_v) begin
                    pair_go = 1'b1;
                end else if (i_in_data.message_last) begin
                    pair_go  = 1'b1;
                    pair_a   = lt.idx;
                    pair_b   = pfc_pkg::LET_X;
                    pair_end = 1'b1;
                end
            end else if (i_in_data.message_last && r_held_v) begin
                pair_go  = 1'b1;
                pair_b   = pfc_pkg::LET_X;
                pair_end = 1'b1;
            end
        end
    end

    // Key placement from a key byte or the finish walk
    always_comb begin
        place_letter = (r_state == pfc_pkg::ST_FILL) ? r_walk : lt.idx;
        place_we     = 1'b0;
        if (!r_used[place_letter] && r_fill < pfc_pkg::CELLS) begin
            if (r_state == pfc_pkg::ST_FILL) begin
                place_we = (r_walk != pfc_pkg::LET_J);
            end else if (in_fire && i_in_data.opcode == pfc_pkg::OP_KEY) begin
                place_we = lt.valid;
            end
        end
    end

    // Square addresses from the two places
    always_comb begin
        r1       = pfc_pkg::row_of(place_rd0);
        c1       = pfc_pkg::col_of(place_rd0);
        r2       = pfc_pkg::row_of(place_rd1);
        c2       = pfc_pkg::col_of(place_rd1);
        sq_re    = (r_state == pfc_pkg::ST_POS);
        if (r1 == r2) begin
            sq_addr0 = pfc_pkg::cell_of(r1, pfc_pkg::shift5(c1, r_dir));
            sq_addr1 = pfc_pkg::cell_of(r2, pfc_pkg::shift5(c2, r_dir));
        end else if (c1 == c2) begin
            sq_addr0 = pfc_pkg::cell_of(pfc_pkg::shift5(r1, r_dir), c1);
            sq_addr1 = pfc_pkg::cell_of(pfc_pkg::shift5(r2, r_dir), c2);
        end else begin
            sq_addr0 = pfc_pkg::cell_of(r1, c2);
            sq_addr1 = pfc_pkg::cell_of(r2, c1);
        end
    end

    // Letter to cell index; writes never meet a pending read of the same transaction
    pfc_ram #(.WIDTH(5), .DEPTH(26)) u_place (
        .i_clk    (i_clk),
        .i_we     (place_we),
        .i_waddr  (place_letter),
        .i_wdata  (r_fill),
        .i_re     (pair_go),
        .i_raddr0 (pair_a),
        .i_raddr1 (pair_b),
        .o_rdata0 (place_rd0),
        .o_rdata1 (place_rd1)
    );

    // Cell index to letter
    pfc_ram #(.WIDTH(5), .DEPTH(25)) u_square (
        .i_clk    (i_clk),
        .i_we     (place_we),
        .i_waddr  (r_fill),
        .i_wdata  (place_letter),
        .i_re     (sq_re),
        .i_raddr0 (sq_addr0),
        .i_raddr1 (sq_addr1),
        .o_rdata0 (sq_rd0),
        .o_rdata1 (sq_rd1)
    );

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            pfc_pkg::ST_IDLE: begin
                if (in_fire && i_in_data.opcode == pfc_pkg::OP_FINISH) begin
                    n_state = pfc_pkg::ST_FILL;
                end else if (pair_go) begin
                    n_state = pfc_pkg::ST_POS;
                end
            end
            pfc_pkg::ST_FILL: begin
                if (r_walk == pfc_pkg::LETTERS - 5'd1) begin
                    n_state = pfc_pkg::ST_IDLE;
                end
            end
            pfc_pkg::ST_POS: n_state = pfc_pkg::ST_SQ;
            pfc_pkg::ST_SQ: begin
                if (out_free) n_state = pfc_pkg::ST_EMIT2;
            end
            pfc_pkg::ST_EMIT2: begin
                if (out_free) n_state = pfc_pkg::ST_IDLE;
            end
            default: n_state = pfc_pkg::ST_IDLE;
        endcase
    end

    // Datapath and output register
    always_comb begin
        n_used      = r_used;
        n_fill      = r_fill;
        n_held      = r_held;
        n_held_v    = r_held_v;
        n_walk      = r_walk;
        n_end       = r_end;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        if (place_we) begin
            n_used[place_letter] = 1'b1;
            n_fill               = r_fill + 5'd1;
        end
        case (r_state)
            pfc_pkg::ST_IDLE: begin
                n_walk = 5'd0;
                if (in_fire) begin
                    case (i_in_data.opcode)
                        pfc_pkg::OP_CLEAR: begin
                            n_used   = '0;
                            n_fill   = 5'd0;
                            n_held_v = 1'b0;
                        end
                        pfc_pkg::OP_TEXT: begin
                            if (pair_go) begin
                                n_held_v = 1'b0;
                                n_end    = pair_end;
                            end else if (lt.valid) begin
                                n_held   = lt.idx;
                                n_held_v = 1'b1;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            pfc_pkg::ST_FILL: n_walk = r_walk + 5'd1;
            pfc_pkg::ST_SQ: begin
                if (out_free) begin
                    n_out_valid       = 1'b1;
                    n_out.letter      = pfc_pkg::OUT_BASE + {2'b00, sq_rd0};
                    n_out.pair_second = 1'b0;
                    n_out.message_end = 1'b0;
                end
            end
            pfc_pkg::ST_EMIT2: begin
                if (out_free) begin
                    n_out_valid       = 1'b1;
                    n_out.letter      = pfc_pkg::OUT_BASE + {2'b00, sq_rd1};
                    n_out.pair_second = 1'b1;
                    n_out.message_end = r_end;
                end
            end
            default: ;
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= pfc_pkg::ST_IDLE;
            r_used      <= '0;
            r_fill      <= 5'd0;
            r_held_v    <= 1'b0;
            r_out_valid <= 1'b0;
            r_dir       <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_used      <= n_used;
            r_fill      <= n_fill;
            r_held_v    <= n_held_v;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                r_dir <= i_cfg_data;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_held <= n_held;
        r_walk <= n_walk;
        r_end  <= n_end;
        r_out  <= n_out;
    end

`ifndef SYNTHESIS
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= pfc_pkg::CELLS)
        else $error("fill count beyond square size");

    a_no_replace: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        place_we |=> r_used[$past(place_letter)] && r_fill == $past(r_fill) + 5'd1)
        else $error("placement did not mark letter and advance fill");

    a_fill_skips_j: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == pfc_pkg::ST_FILL && place_we) |-> place_letter != pfc_pkg::LET_J)
        else $error("finish walk placed j");

    a_pos_to_sq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == pfc_pkg::ST_POS) |=> (r_state == pfc_pkg::ST_SQ))
        else $error("square read not issued after place read");

    a_second_letter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == pfc_pkg::ST_EMIT2 && out_free) |=>
            (o_out_valid && o_out_data.pair_second))
        else $error("second letter of pair not presented");
`endif

endmodule

>>> tb/playfair_cipher_engine_tb.sv
module playfair_cipher_engine_tb;

    localparam int SIDE          = 5;
    localparam int PHASES        = 10;
    localparam int OPENING_ROWS  = 27;
    localparam int HOLD_CYCLES   = 400;
    localparam int SETTLE_CYCLES = 40;
    localparam int STALL_LIMIT   = 5000;
    localparam int PRINT_CAP     = 50;

    localparam pfc_pkg::t_out NO_LETTER = '0;

    // One row of the opening script; fix_count < 0 leaves the check to the predictor
    typedef struct {
        pfc_pkg::t_opcode op;
        logic [7:0]       chr;
        logic             last;
        int               fix_count;
        pfc_pkg::t_out    fix0;
        pfc_pkg::t_out    fix1;
    } t_script_row;

    logic          i_clk;
    logic          i_rst_n;
    logic          i_in_valid;
    logic          o_in_ready;
    pfc_pkg::t_in  i_in_data;
    logic          o_out_valid;
    logic          i_out_ready;
    pfc_pkg::t_out o_out_data;
    logic          i_cfg_valid;
    logic          o_cfg_ready;
    logic          i_cfg_data;

    // Predictor state: square cells, letter positions, used flags, held letter
    logic [4:0] sq_cell [pfc_pkg::CELLS];
    logic [4:0] sq_pos  [pfc_pkg::LETTERS];
    bit         sq_has  [pfc_pkg::LETTERS];
    int         sq_fill;
    logic [4:0] held_ltr;
    bit         held_ok;
    bit         decrypt_on;

    // Cipher letters still owed by the block, oldest first
    pfc_pkg::t_out cipher_letters_due [$];
    pfc_pkg::t_out want;

    int  n_mismatch;
    int  letters_checked;
    int  commands_sent;
    int  text_bytes;
    int  dir_writes;
    int  holds_done;
    int  burst_left;
    bit  tx_steady;
    bit  hold_req;
    int  rx_mode;
    int  rx_tick;
    int  quiet;

    // Opening script: alphabetical square first, so a few pairs read off directly
    t_script_row opening_script [OPENING_ROWS] = '{
        '{pfc_pkg::OP_CLEAR,  8'h00, 1'b1, -1, NO_LETTER, NO_LETTER},
        '{pfc_pkg::OP_FINISH, 8'hFF, 1'b0, -1, NO_LETTER, NO_LETTER},
        '{pfc_pkg::OP_FINISH, 8'h00, 1'b1, -1, NO_LETTER, NO_LETTER},   // finish twice
        '{pfc_pkg::OP_KEY,    8'h51, 1'b0, -1, NO_LETTER, NO_LETTER},   // key on full square
        '{pfc_pkg::OP_TEXT,   8'h65, 1'b0, -1, NO_LETTER, NO_LETTER},
        // e,A: same row with wrap -> a,b
        '{pfc_pkg::OP_TEXT,   8'h41, 1'b0,  2, '{7'd97,  1'b0, 1'b0}, '{7'd98,  1'b1, 1'b0}},
        '{pfc_pkg::OP_TEXT,   8'h7A, 1'b0, -1, NO_LETTER, NO_LETTER},
        // z,E: same column with wrap -> e,k
        '{pfc_pkg::OP_TEXT,   8'h45, 1'b0,  2, '{7'd101, 1'b0, 1'b0}, '{7'd107, 1'b1, 1'b0}},
        // lone J closing a message: i with x -> h,y
        '{pfc_pkg::OP_TEXT,   8'h4A, 1'b1,  2, '{7'd104, 1'b0, 1'b0}, '{7'd121, 1'b1, 1'b1}},
        '{pfc_pkg::OP_TEXT,   8'hFF, 1'b0, -1, NO_LETTER, NO_LETTER},
        '{pfc_pkg::OP_TEXT,   8'h6D, 1'b0, -1, NO_LETTER, NO_LETTER},
        // end mark on a space with m held: m with x -> n,w
        '{pfc_pkg::OP_TEXT,   8'h20, 1'b1,  2, '{7'd110, 1'b0, 1'b0}, '{7'd119, 1'b1, 1'b1}},
        // end mark on a non-letter with nothing held
        '{pfc_pkg::OP_TEXT,   8'h80, 1'b1,  0, NO_LETTER, NO_LETTER},
        '{pfc_pkg::OP_TEXT,   8'h62, 1'b0, -1, NO_LETTER, NO_LETTER},   // held, then dropped
        '{pfc_pkg::OP_CLEAR,  8'h00, 1'b0, -1, NO_LETTER, NO_LETTER},
        '{pfc_pkg::OP_KEY,    8'h5A, 1'b0, -1, NO_LETTER, NO_LETTER},
        '{pfc_pkg::OP_KEY,    8'h6A, 1'b1, -1, NO_LETTER, NO_LETTER},   // j folds to i
        '{pfc_pkg::OP_KEY,    8'h5B, 1'b0, -1, NO_LETTER, NO_LETTER},
        '{pfc_pkg::OP_TEXT,   8'h63, 1'b0, -1, NO_LETTER, NO_LETTER},   // partial, stale cells
        '{pfc_pkg::OP_TEXT,   8'h44, 1'b0, -1, NO_LETTER, NO_LETTER},
        '{pfc_pkg::OP_KEY,    8'h49, 1'b0, -1, NO_LETTER, NO_LETTER},   // dup of folded j
        '{pfc_pkg::OP_KEY,    8'h60, 1'b1, -1, NO_LETTER, NO_LETTER},
        '{pfc_pkg::OP_FINISH, 8'h00, 1'b0, -1, NO_LETTER, NO_LETTER},
        '{pfc_pkg::OP_TEXT,   8'h6D, 1'b0, -1, NO_LETTER, NO_LETTER},
        '{pfc_pkg::OP_TEXT,   8'h4D, 1'b0, -1, NO_LETTER, NO_LETTER},   // doubled, no filler
        '{pfc_pkg::OP_TEXT,   8'h7B, 1'b0, -1, NO_LETTER, NO_LETTER},
        '{pfc_pkg::OP_TEXT,   8'h71, 1'b0, -1, NO_LETTER, NO_LETTER}    // held across flip
    };

    playfair_cipher_engine u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // ---------------------------------------------------------------- predictor

    // Letter index of an ASCII byte, j folded into i; -1 for a non-letter
    function automatic int fold_to_index(input logic [7:0] b);
        logic [7:0] low;
        int         idx;
        low = b | 8'h20;
        if (low < 8'h61 || low > 8'h7A) return -1;
        idx = int'(low - 8'h61);
        if (idx == int'(pfc_pkg::LET_J)) idx = int'(pfc_pkg::LET_I);
        return idx;
    endfunction

    task automatic sq_add(input int l);
        if (!sq_has[l] && sq_fill < int'(pfc_pkg::CELLS)) begin
            sq_cell[sq_fill] = 5'(l);
            sq_pos[l]        = 5'(sq_fill);
            sq_has[l]        = 1'b1;
            sq_fill++;
        end
    endtask

    function automatic pfc_pkg::t_out letter_result(input int l, input bit second,
                                                    input bit closes);
        pfc_pkg::t_out r;
        r.letter      = pfc_pkg::OUT_BASE + 7'(l);
        r.pair_second = second;
        r.message_end = closes;
        return r;
    endfunction

    // Same row / same column / rectangle rules; decrypt steps back by one
    task automatic encode_pair(input logic [4:0] a, input logic [4:0] b, input bit closes,
                               output pfc_pkg::t_out r0, output pfc_pkg::t_out r1);
        int pa, pb, ra, ca, rb, cb, step, oa, ob;
        pa   = int'(sq_pos[a]);
        pb   = int'(sq_pos[b]);
        ra   = pa / SIDE;
        ca   = pa % SIDE;
        rb   = pb / SIDE;
        cb   = pb % SIDE;
        step = decrypt_on ? SIDE - 1 : 1;
        if (ra == rb) begin
            oa = int'(sq_cell[ra * SIDE + (ca + step) % SIDE]);
            ob = int'(sq_cell[rb * SIDE + (cb + step) % SIDE]);
        end else if (ca == cb) begin
            oa = int'(sq_cell[((ra + step) % SIDE) * SIDE + ca]);
            ob = int'(sq_cell[((rb + step) % SIDE) * SIDE + cb]);
        end else begin
            oa = int'(sq_cell[ra * SIDE + cb]);
            ob = int'(sq_cell[rb * SIDE + ca]);
        end
        r0 = letter_result(oa, 1'b0, 1'b0);
        r1 = letter_result(ob, 1'b1, closes);
    endtask

    task automatic playfair_predict(input pfc_pkg::t_in it, output int n,
                                    output pfc_pkg::t_out r0, output pfc_pkg::t_out r1);
        int l;
        int k;
        n  = 0;
        r0 = '0;
        r1 = '0;
        l  = fold_to_index(it.char_byte);
        case (it.opcode)
            pfc_pkg::OP_CLEAR: begin
                for (k = 0; k < int'(pfc_pkg::LETTERS); k++) sq_has[k] = 1'b0;
                sq_fill = 0;
                held_ok = 1'b0;
            end
            pfc_pkg::OP_KEY: begin
                if (l >= 0) sq_add(l);
            end
            pfc_pkg::OP_FINISH: begin
                for (k = 0; k < int'(pfc_pkg::LETTERS); k++) begin
                    if (k != int'(pfc_pkg::LET_J)) sq_add(k);
                end
            end
            pfc_pkg::OP_TEXT: begin
                if (l >= 0) begin
                    if (held_ok) begin
                        held_ok = 1'b0;
                        encode_pair(held_ltr, 5'(l), it.message_last, r0, r1);
                        n = 2;
                    end else if (it.message_last) begin
                        encode_pair(5'(l), pfc_pkg::LET_X, 1'b1, r0, r1);
                        n = 2;
                    end else begin
                        held_ltr = 5'(l);
                        held_ok  = 1'b1;
                    end
                end else if (it.message_last && held_ok) begin
                    held_ok = 1'b0;
                    encode_pair(held_ltr, pfc_pkg::LET_X, 1'b1, r0, r1);
                    n = 2;
                end
            end
            default: ;
        endcase
    endtask

    // ---------------------------------------------------------------- drivers

    function automatic pfc_pkg::t_in make_op(input pfc_pkg::t_opcode op,
                                             input logic [7:0] chr, input logic last);
        pfc_pkg::t_in it;
        it.opcode       = op;
        it.char_byte    = chr;
        it.message_last = last;
        return it;
    endfunction

    function automatic logic [7:0] letter_byte();
        logic [7:0] base;
        base = $urandom_range(0, 1) ? 8'h41 : 8'h61;
        return base + 8'($urandom_range(0, 25));
    endfunction

    function automatic logic [7:0] any_key_byte();
        return ($urandom_range(0, 99) < 85) ? letter_byte() : 8'($urandom);
    endfunction

    // Offer one transaction, hold it until taken, then book the letters it owes
    task automatic issue_op(input pfc_pkg::t_in it, input int fix_count,
                            input pfc_pkg::t_out f0, input pfc_pkg::t_out f1);
        int            n;
        pfc_pkg::t_out r0;
        pfc_pkg::t_out r1;
        i_in_valid <= 1'b1;
        i_in_data  <= it;
        do @(posedge i_clk); while (o_in_ready !== 1'b1);
        playfair_predict(it, n, r0, r1);
        if (fix_count >= 0) begin
            n  = fix_count;
            r0 = f0;
            r1 = f1;
        end
        if (n == 2) begin
            cipher_letters_due.push_back(r0);
            cipher_letters_due.push_back(r1);
        end
        commands_sent++;
        if (it.opcode == pfc_pkg::OP_TEXT) text_bytes++;
        // bursts with random gaps, unless this phase runs back to back
        if (!tx_steady) begin
            if (burst_left == 0) begin
                i_in_valid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge i_clk);
                burst_left = $urandom_range(1, 16);
            end else begin
                burst_left--;
            end
        end
    endtask

    task automatic send(input pfc_pkg::t_in it);
        issue_op(it, -1, NO_LETTER, NO_LETTER);
    endtask

    task automatic write_direction(input logic dir_bit);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= dir_bit;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        decrypt_on = dir_bit;
        i_cfg_valid <= 1'b0;
        dir_writes++;
    endtask

    // Quiet the input, collect every owed letter, then let the block go idle
    task automatic settle();
        i_in_valid <= 1'b0;
        while (cipher_letters_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Mostly a key build then message text, with noise mixed in
    task automatic run_phase(input int p);
        int n_key;
        int n_text;
        int r;
        int k;
        tx_steady = (p % 3 == 1);
        if (p == 3) hold_req = 1'b1;
        if (p != 0 && $urandom_range(0, 3) != 0) begin
            send(make_op(pfc_pkg::OP_CLEAR, 8'($urandom), 1'($urandom)));
            n_key = $urandom_range(0, 30);
            for (k = 0; k < n_key; k++) begin
                send(make_op(pfc_pkg::OP_KEY, any_key_byte(), 1'($urandom)));
            end
            send(make_op(pfc_pkg::OP_FINISH, 8'($urandom), 1'($urandom)));
        end
        n_text = $urandom_range(100, 130);
        for (k = 0; k < n_text; k++) begin
            r = $urandom_range(0, 99);
            if (r < 82) begin
                send(make_op(pfc_pkg::OP_TEXT, letter_byte(), $urandom_range(0, 9) == 0));
            end else if (r < 90) begin
                send(make_op(pfc_pkg::OP_TEXT, 8'($urandom), $urandom_range(0, 5) == 0));
            end else if (r < 97) begin
                send(make_op(pfc_pkg::OP_KEY, any_key_byte(), 1'($urandom)));
            end else if (r < 99) begin
                send(make_op(pfc_pkg::OP_FINISH, 8'($urandom), 1'($urandom)));
            end else begin
                send(make_op(pfc_pkg::OP_CLEAR, 8'($urandom), 1'($urandom)));
            end
        end
    endtask

    // ---------------------------------------------------------------- receiver

    // Own stall pattern, plus one long hold-off on request
    initial begin
        i_out_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                i_out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                holds_done++;
            end else begin
                rx_tick++;
                if (rx_tick % 180 == 0) rx_mode = $urandom_range(0, 3);
                case (rx_mode)
                    0: i_out_ready <= 1'b1;
                    1: i_out_ready <= ($urandom_range(0, 99) < 75);
                    2: i_out_ready <= (rx_tick % 7) > 1;
                    default: i_out_ready <= ($urandom_range(0, 99) < 30);
                endcase
            end
        end
    end

    // ---------------------------------------------------------------- checking

    task automatic flag_mismatch(input string what, input int got, input int exp_val);
        if (n_mismatch < PRINT_CAP) begin
            $display("ERROR %s: got %0d, expected %0d (after %0d letters)",
                     what, got, exp_val, letters_checked);
        end
        n_mismatch++;
    endtask

    // Compare each accepted letter with the oldest one owed
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (cipher_letters_due.size() == 0) begin
                flag_mismatch("letter with nothing owed", int'(o_out_data.letter), 0);
            end else begin
                want = cipher_letters_due.pop_front();
                if (o_out_data.letter !== want.letter)
                    flag_mismatch("letter", int'(o_out_data.letter), int'(want.letter));
                if (o_out_data.pair_second !== want.pair_second)
                    flag_mismatch("pair_second", int'(o_out_data.pair_second),
                                  int'(want.pair_second));
                if (o_out_data.message_end !== want.message_end)
                    flag_mismatch("message_end", int'(o_out_data.message_end),
                                  int'(want.message_end));
                letters_checked++;
            end
        end
    end

    // Watchdog: too long without any transaction on any channel
    initial begin
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
                (i_cfg_valid && o_cfg_ready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("Watchdog: %0d cycles without a transaction", STALL_LIMIT);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // ---------------------------------------------------------------- main flow

    initial begin
        int k;
        int p;
        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_in_data   <= '0;
        i_cfg_valid <= 1'b0;
        i_cfg_data  <= 1'b0;
        for (k = 0; k < int'(pfc_pkg::CELLS); k++) sq_cell[k] = '0;
        for (k = 0; k < int'(pfc_pkg::LETTERS); k++) begin
            sq_pos[k] = '0;
            sq_has[k] = 1'b0;
        end
        sq_fill    = 0;
        held_ltr   = '0;
        held_ok    = 1'b0;
        decrypt_on = 1'b0;
        burst_left = $urandom_range(1, 16);
        tx_steady  = 1'b0;
        hold_req   = 1'b0;
        rx_mode    = 0;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        write_direction(1'b0);

        // opening script
        for (k = 0; k < OPENING_ROWS; k++) begin
            issue_op(make_op(opening_script[k].op, opening_script[k].chr,
                             opening_script[k].last),
                     opening_script[k].fix_count,
                     opening_script[k].fix0, opening_script[k].fix1);
        end

        // random phases, direction rewritten between them
        for (p = 0; p < PHASES; p++) begin
            settle();
            if (p == 0)      write_direction(1'b1);
            else if (p == 1) write_direction(1'b0);
            else             write_direction(1'($urandom_range(0, 1)));
            run_phase(p);
        end
        settle();

        $display("Run covered %0d commands (%0d text bytes) and %0d cipher letters,",
                 commands_sent, text_bytes, letters_checked);
        $display("with %0d direction writes and %0d long output hold-off(s).",
                 dir_writes, holds_done);
        if (n_mismatch == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

>>> files.f
hw/rtl/pfc_pkg.sv
hw/rtl/pfc_ram.sv
hw/rtl/playfair_cipher_engine.sv
tb/playfair_cipher_engine_tb.sv
